// ===== hdl/bole_pkg.sv =====
// shared types, sizes and codes for the bounded ordered list engine
// no dependencies; compiled first
package bole_pkg;

  localparam int CAPACITY = 128;
  localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = 8;
  localparam int XW = ((CW > PW) ? CW : PW) + 1;

  localparam logic [2:0] RQ_APPEND     = 3'd0;
  localparam logic [2:0] RQ_INSERT     = 3'd1;
  localparam logic [2:0] RQ_REMOVE_POS = 3'd2;
  localparam logic [2:0] RQ_REMOVE_KEY = 3'd3;
  localparam logic [2:0] RQ_FIND       = 3'd4;
  localparam logic [2:0] RQ_READ       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        payload;
  } entry_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,
    CM_DEL,
    CM_ROT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t      mode;
    logic [IW-1:0]   idx;
    logic            keep;
  } cell_ctrl_t;

endpackage

// ===== hdl/bole_if.sv =====
// request and response channel interfaces, valid/ready handshake
// depends on nothing but the signal widths of the list engine
interface bole_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [7:0]         position;
  logic signed [31:0] element_key;
  logic [31:0]        element_payload;

  modport source (output valid, req_type, position, element_key, element_payload,
                  input ready);
  modport sink (input valid, req_type, position, element_key, element_payload,
                output ready);
endinterface

interface bole_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               hit;
  logic signed [31:0] found_key;
  logic [31:0]        found_payload;
  logic [7:0]         entry_total;

  modport source (output valid, status, hit, found_key, found_payload, entry_total,
                  input ready);
  modport sink (input valid, status, hit, found_key, found_payload, entry_total,
                output ready);
endinterface

// ===== hdl/bole_cell.sv =====
// one slot of the list: holds an entry and trades it with its neighbours
// depends on bole_pkg
module bole_cell (
  input  logic                clk,
  input  logic [bole_pkg::IW-1:0] my_idx,
  input  bole_pkg::cell_ctrl_t ctrl,
  input  bole_pkg::entry_t    left,
  input  bole_pkg::entry_t    right,
  input  bole_pkg::entry_t    head,
  input  bole_pkg::entry_t    new_ent,
  output bole_pkg::entry_t    q
);
  import bole_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CM_INS: begin
        if (my_idx > ctrl.idx) begin
          q <= left;
        end else if (my_idx == ctrl.idx) begin
          q <= new_ent;
        end
      end
      CM_DEL: begin
        if (my_idx >= ctrl.idx) begin
          q <= right;
        end
      end
      CM_ROT: begin
        // the tail slot takes the old head back unless it is dropped, everyone else moves down
        if (ctrl.keep && (my_idx == ctrl.idx)) begin
          q <= head;
        end else begin
          q <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/bole_chain.sv =====
// row of list cells wired to their neighbours; slot 0 is the head
// depends on bole_pkg and bole_cell
module bole_chain (
  input  logic                 clk,
  input  bole_pkg::cell_ctrl_t ctrl,
  input  bole_pkg::entry_t     new_ent,
  output bole_pkg::entry_t     head
);
  import bole_pkg::*;

  entry_t slot_q [CAPACITY];

  assign head = slot_q[0];

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    entry_t left_d;
    entry_t right_d;

    if (gi == 0) begin : g_first
      assign left_d = new_ent;
    end else begin : g_mid_l
      assign left_d = slot_q[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = slot_q[0];
    end else begin : g_mid_r
      assign right_d = slot_q[gi+1];
    end

    bole_cell u_cell (
      .clk     (clk),
      .my_idx  (IW'(gi)),
      .ctrl    (ctrl),
      .left    (left_d),
      .right   (right_d),
      .head    (slot_q[0]),
      .new_ent (new_ent),
      .q       (slot_q[gi])
    );
  end

endmodule

// ===== hdl/bounded_ordered_list_engine_core.sv =====
// Bounded ordered list engine, top level. Keeps up to CAPACITY (128) entries, each a signed
// 32-bit key with a 32-bit payload, in a row of cells; positions count from 1. One request
// on req gives exactly one response on rsp carrying status, hit, the entry found or read and
// the entry count. Append, insert and remove at a position shift every slot from that
// position on by one slot together. Find key, read position and remove key turn the list
// once through the head cell, one entry per cycle; a request refused for a full or empty
// list or a bad position is answered without turning the list. A new request
// is taken once the previous one has been handed to the response register, so a response
// waiting on rsp does not hold off the next request.
// depends on bole_pkg, bole_if and bole_chain
module bounded_ordered_list_engine_core (
  input  logic clk,
  input  logic rst,
  bole_req_if.sink   req,
  bole_rsp_if.source rsp
);
  import bole_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_FIN
  } state_t;

  state_t        state;
  logic [CW-1:0] fill;
  logic [2:0]    op;
  logic signed [31:0] key_q;
  logic [IW-1:0] tgt;
  logic [IW-1:0] step;
  logic [IW-1:0] last;
  logic          removed;

  // pending result, moved to rsp in S_FIN
  logic [1:0]         res_status;
  logic               res_hit;
  logic signed [31:0] res_key;
  logic [31:0]        res_pay;

  // decode of the accepted request
  logic          accept;
  cell_ctrl_t    cell_ctrl;
  entry_t        new_ent;
  entry_t        head;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] fill_x;
  logic [1:0]    imm_status;
  logic          go_rot;
  logic [CW-1:0] fill_next;
  logic          is_full;
  logic          is_empty;
  logic          match;
  logic          drop;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign pos_x    = XW'(req.position);
  assign fill_x   = XW'(fill);
  assign is_full  = (fill_x >= XW'(CAPACITY));
  assign is_empty = (fill == '0);
  assign new_ent  = '{key: req.element_key, payload: req.element_payload};

  // head comparison while the list turns round
  assign match = (head.key == key_q);
  assign drop  = (op == RQ_REMOVE_KEY) && match;

  always_comb begin
    cell_ctrl  = '{mode: CM_HOLD, idx: '0, keep: 1'b0};
    imm_status = ST_OK;
    go_rot     = 1'b0;
    fill_next  = fill;
    if (state == S_IDLE && accept) begin
      case (req.req_type)
        RQ_APPEND: begin
          if (is_full) begin
            imm_status = ST_FULL;
          end else begin
            cell_ctrl = '{mode: CM_INS, idx: IW'(fill), keep: 1'b0};
            fill_next = fill + 1'b1;
          end
        end
        RQ_INSERT: begin
          if (is_full) begin
            imm_status = ST_FULL;
          end else if (pos_x == '0 || pos_x > fill_x + 1'b1) begin
            imm_status = ST_BAD;
          end else begin
            cell_ctrl = '{mode: CM_INS, idx: IW'(pos_x - 1'b1), keep: 1'b0};
            fill_next = fill + 1'b1;
          end
        end
        RQ_REMOVE_POS: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else if (pos_x == '0 || pos_x > fill_x) begin
            imm_status = ST_BAD;
          end else begin
            cell_ctrl = '{mode: CM_DEL, idx: IW'(pos_x - 1'b1), keep: 1'b0};
            fill_next = fill - 1'b1;
          end
        end
        RQ_REMOVE_KEY, RQ_FIND: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else begin
            go_rot = 1'b1;
          end
        end
        RQ_READ: begin
          if (is_empty) begin
            imm_status = ST_EMPTY;
          end else if (pos_x == '0 || pos_x > fill_x) begin
            imm_status = ST_BAD;
          end else begin
            go_rot = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_ROT) begin
      // survivors go back in at the current tail, matches fall out
      cell_ctrl = '{mode: CM_ROT, idx: IW'(fill - 1'b1), keep: !drop};
      if (drop) begin
        fill_next = fill - 1'b1;
      end
    end
  end

  bole_chain u_chain (
    .clk     (clk),
    .ctrl    (cell_ctrl),
    .new_ent (new_ent),
    .head    (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      fill <= fill_next;
      // S_FIN reloads the response register itself
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req.req_type;
            key_q      <= req.element_key;
            tgt        <= IW'(pos_x - 1'b1);
            step       <= '0;
            last       <= IW'(fill - 1'b1);
            removed    <= 1'b0;
            res_status <= imm_status;
            res_hit    <= 1'b0;
            res_key    <= '0;
            res_pay    <= '0;
            state      <= go_rot ? S_ROT : S_FIN;
          end
        end
        S_ROT: begin
          if (drop) begin
            removed <= 1'b1;
          end
          if ((op == RQ_FIND && match && !res_hit) || (op == RQ_READ && step == tgt)) begin
            res_hit <= 1'b1;
            res_key <= head.key;
            res_pay <= head.payload;
          end
          step <= step + 1'b1;
          if (step == last) begin
            // whole list has been round once, order restored
            case (op)
              RQ_REMOVE_KEY: res_status <= (removed || drop) ? ST_OK : ST_BAD;
              RQ_FIND:       res_status <= (res_hit || match) ? ST_OK : ST_BAD;
              default:       res_status <= ST_OK;
            endcase
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.hit           <= res_hit;
            rsp.found_key     <= res_key;
            rsp.found_payload <= res_pay;
            rsp.entry_total   <= 8'(fill);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/bole_checker.sv =====
// port-level checks on the list engine response channel, bound to the top level
// depends on bole_pkg and bounded_ordered_list_engine_core
module bole_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic               hit,
  input logic signed [31:0] found_key,
  input logic [31:0]        found_payload,
  input logic [7:0]         entry_total
);
  import bole_pkg::*;

  // stalled response keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(hit)
      && $stable(found_key) && $stable(found_payload) && $stable(entry_total))
    else $error("response changed while stalled");

  // an entry is only returned on success
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> status == ST_OK)
    else $error("hit with non-ok status");

  // no entry means zero key and payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> found_key == '0 && found_payload == '0)
    else $error("entry fields not cleared on miss");

  // full refusal only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_total == 8'(CAPACITY))
    else $error("full status with list not full");

endmodule

bind bounded_ordered_list_engine_core bole_checker u_bole_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .hit           (rsp.hit),
  .found_key     (rsp.found_key),
  .found_payload (rsp.found_payload),
  .entry_total   (rsp.entry_total)
);

// ===== bench/bounded_ordered_list_engine_core_test.sv =====
// self-checking bench for the bounded ordered list engine: directed corner requests, then
// random list traffic with stalls on both channels, checked against a shadow copy of the list
// depends on bole_pkg, bole_if and the bounded_ordered_list_engine_core rtl
module bounded_ordered_list_engine_core_test;
  import bole_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // request codes the block has no use for, still legal on the 3-bit field
  localparam logic [2:0] RQ_SPARE_A = 3'd6;
  localparam logic [2:0] RQ_SPARE_B = 3'd7;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  localparam int RANDOM_PER_PHASE = 570;
  localparam int LONG_HOLD        = 400;
  localparam int STALL_LIMIT      = 4000;
  localparam int DRAIN_CYCLES     = 300;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         pos;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } list_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [7:0]         total;
  } list_rsp_t;

  logic clk;
  logic rst;

  bole_req_if req_ch ();
  bole_rsp_if rsp_ch ();

  bounded_ordered_list_engine_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the list, updated as each request transfer happens
  entry_t shadow_list [CAPACITY];
  int     shadow_count = 0;
  int     peak_count   = 0;

  list_req_t req_backlog [$];
  list_rsp_t awaited_rsp [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_request = 1'b0;

  int fail_count    = 0;
  int req_transfers = 0;
  int rsp_transfers = 0;
  int hits_seen     = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // works out the response to one request and moves the shadow list on
  function automatic list_rsp_t apply_list_request(list_req_t r);
    list_rsp_t o;
    int        p;
    int        slot;
    int        w;
    o = '0;
    p = int'(r.pos);
    case (r.kind)
      RQ_APPEND, RQ_INSERT: begin
        // a full list wins over a bad insert position
        if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (r.kind == RQ_INSERT && (p < 1 || p > shadow_count + 1)) begin
          o.status = ST_BAD;
        end else begin
          slot = (r.kind == RQ_APPEND) ? shadow_count : p - 1;
          for (int i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i - 1];
          shadow_list[slot].key     = r.key;
          shadow_list[slot].payload = r.payload;
          shadow_count++;
        end
      end
      RQ_REMOVE_POS: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else if (p < 1 || p > shadow_count) begin
          o.status = ST_BAD;
        end else begin
          for (int i = p - 1; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
        end
      end
      RQ_REMOVE_KEY: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          // compact the survivors towards the head
          w = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_list[i].key != r.key) begin
              shadow_list[w] = shadow_list[i];
              w++;
            end
          end
          if (w == shadow_count) o.status = ST_BAD;
          shadow_count = w;
        end
      end
      RQ_FIND: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.status = ST_BAD;
          for (int i = 0; i < shadow_count; i++) begin
            if (o.hit == 1'b0 && shadow_list[i].key == r.key) begin
              o.status  = ST_OK;
              o.hit     = 1'b1;
              o.key     = shadow_list[i].key;
              o.payload = shadow_list[i].payload;
            end
          end
        end
      end
      RQ_READ: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else if (p < 1 || p > shadow_count) begin
          o.status = ST_BAD;
        end else begin
          o.hit     = 1'b1;
          o.key     = shadow_list[p - 1].key;
          o.payload = shadow_list[p - 1].payload;
        end
      end
      default: begin
        // spare codes leave the list alone and report ok
        o.status = ST_OK;
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    o.total = 8'(shadow_count);
    return o;
  endfunction

  // random request shaped by the current shadow depth; growing favours adds
  function automatic list_req_t random_request(bit growing);
    list_req_t r;
    int        roll;
    int        n;
    n = shadow_count;
    r.payload = $urandom;
    roll = $urandom_range(99);
    if (roll < 35 && n > 0) begin
      // key already in the list, so finds and key removals hit
      r.key = shadow_list[$urandom_range(n - 1)].key;
    end else if (roll < 75) begin
      // small pool so that duplicate keys pile up
      case ($urandom_range(7))
        0: r.key = KEY_MIN;
        1: r.key = KEY_MAX;
        2: r.key = -32'sd1;
        default: r.key = $urandom_range(20);
      endcase
    end else begin
      r.key = $urandom;
    end
    r.pos = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 10) begin
      // noise: any code, any position
      r.kind = 3'($urandom_range(7));
      return r;
    end
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 35)      r.kind = RQ_APPEND;
      else if (roll < 65) r.kind = RQ_INSERT;
      else if (roll < 75) r.kind = RQ_REMOVE_POS;
      else if (roll < 80) r.kind = RQ_REMOVE_KEY;
      else if (roll < 90) r.kind = RQ_FIND;
      else                r.kind = RQ_READ;
    end else begin
      if (roll < 10)      r.kind = RQ_APPEND;
      else if (roll < 20) r.kind = RQ_INSERT;
      else if (roll < 55) r.kind = RQ_REMOVE_POS;
      else if (roll < 70) r.kind = RQ_REMOVE_KEY;
      else if (roll < 85) r.kind = RQ_FIND;
      else                r.kind = RQ_READ;
    end
    if (r.kind == RQ_INSERT) begin
      r.pos = 8'($urandom_range(n + 1, 1));
    end else if (r.kind == RQ_REMOVE_POS || r.kind == RQ_READ) begin
      r.pos = (n > 0) ? 8'($urandom_range(n, 1)) : 8'($urandom_range(2));
    end
    return r;
  endfunction

  task automatic queue_request(input logic [2:0] kind, input logic [7:0] pos,
                               input logic signed [31:0] key, input logic [31:0] payload);
    list_req_t r;
    r.kind    = kind;
    r.pos     = pos;
    r.key     = key;
    r.payload = payload;
    req_backlog.push_back(r);
  endtask

  // sender holds back until every request has gone and every response is back
  task automatic wait_until_drained();
    while (req_backlog.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // request driver: predicts on each transfer, then offers the next queued item
  always @(posedge clk) begin : drive_requests
    list_req_t cur;
    list_req_t nxt;
    if (rst) begin
      req_ch.valid           <= 1'b0;
      req_ch.req_type        <= RQ_APPEND;
      req_ch.position        <= '0;
      req_ch.element_key     <= '0;
      req_ch.element_payload <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cur.kind    = req_ch.req_type;
        cur.pos     = req_ch.position;
        cur.key     = req_ch.element_key;
        cur.payload = req_ch.element_payload;
        awaited_rsp.push_back(apply_list_request(cur));
        req_transfers++;
      end
      // a held item stays put until its transfer
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          req_ch.valid           <= 1'b1;
          req_ch.req_type        <= nxt.kind;
          req_ch.position        <= nxt.pos;
          req_ch.element_key     <= nxt.key;
          req_ch.element_payload <= nxt.payload;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: compares each transfer with the oldest prediction
  always @(posedge clk) begin : collect_responses
    list_rsp_t got;
    list_rsp_t want;
    int        hold_left;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status  = rsp_ch.status;
        got.hit     = rsp_ch.hit;
        got.key     = rsp_ch.found_key;
        got.payload = rsp_ch.found_payload;
        got.total   = rsp_ch.entry_total;
        rsp_transfers++;
        status_seen[got.status]++;
        if (got.hit) hits_seen++;
        if (awaited_rsp.size() == 0) begin
          $display("%0t: response with none awaited, expected nothing, actual %h", $time, got);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("found_key", want.key, got.key);
          check_field("found_payload", want.payload, got.payload);
          check_field("entry_total", 32'(want.total), 32'(got.total));
        end
      end
      // long hold-off lets the block back up and stall its request side
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on stretches with work outstanding but no transfer
  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (req_backlog.size() == 0 && !req_ch.valid && awaited_rsp.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
               $time, quiet_cycles, awaited_rsp.size());
      $display("FAIL bounded_ordered_list_engine_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    bit growing;
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = RQ_APPEND;
    req_ch.position        = '0;
    req_ch.element_key     = '0;
    req_ch.element_payload = '0;
    rsp_ch.ready           = 1'b0;
    send_idle_pct          = 23;
    recv_idle_pct          = 53;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty list refusals
    queue_request(RQ_FIND, 8'd0, 32'sd0, 32'h0);
    queue_request(RQ_READ, 8'd1, 32'sd0, 32'h0);
    queue_request(RQ_REMOVE_POS, 8'd1, 32'sd0, 32'h0);
    queue_request(RQ_REMOVE_KEY, 8'd0, 32'sd0, 32'h0);
    // insert positions just outside 1..count+1
    queue_request(RQ_INSERT, 8'd0, 32'sd5, 32'h1);
    queue_request(RQ_INSERT, 8'd2, 32'sd5, 32'h1);
    // build -1, min, max, 0 using head, tail and count+1 inserts
    queue_request(RQ_INSERT, 8'd1, KEY_MIN, 32'h0000_0000);
    queue_request(RQ_APPEND, 8'd0, KEY_MAX, 32'hffff_ffff);
    queue_request(RQ_INSERT, 8'd3, 32'sd0, 32'h5a5a_a5a5);
    queue_request(RQ_INSERT, 8'd1, -32'sd1, 32'h8000_0001);
    // reads at and beyond the bounds
    queue_request(RQ_READ, 8'd0, 32'sd0, 32'h0);
    queue_request(RQ_READ, 8'd5, 32'sd0, 32'h0);
    queue_request(RQ_READ, 8'd4, 32'sd0, 32'h0);
    queue_request(RQ_READ, 8'd255, 32'sd0, 32'h0);
    // find hit and miss
    queue_request(RQ_FIND, 8'd0, KEY_MAX, 32'h0);
    queue_request(RQ_FIND, 8'd0, 32'sd12345, 32'h0);
    // duplicate key, then a removal that takes both, then a miss
    queue_request(RQ_APPEND, 8'd0, -32'sd1, 32'h0bad_cafe);
    queue_request(RQ_REMOVE_KEY, 8'd0, -32'sd1, 32'h0);
    queue_request(RQ_REMOVE_KEY, 8'd0, -32'sd1, 32'h0);
    // remove positions out of range, then at the head
    queue_request(RQ_REMOVE_POS, 8'd0, 32'sd0, 32'h0);
    queue_request(RQ_REMOVE_POS, 8'd4, 32'sd0, 32'h0);
    queue_request(RQ_REMOVE_POS, 8'd1, 32'sd0, 32'h0);
    // spare codes
    queue_request(RQ_SPARE_A, 8'd1, 32'sd0, 32'h0);
    queue_request(RQ_SPARE_B, 8'd255, -32'sd1, 32'hffff_ffff);
    wait_until_drained();

    // three idle profiles: sender light, receiver light, then none
    growing = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int issued = 0; issued < RANDOM_PER_PHASE; issued++) begin
        if (issued == 150 && phase != 1) hold_off_request = 1'b1;
        // mid-phase pause with nothing in flight
        if (issued == 300 && phase == 1) wait_until_drained();
        while (req_backlog.size() >= 2) @(posedge clk);
        // sweep the depth between empty and full, lingering when full
        if (growing && shadow_count >= CAPACITY && $urandom_range(7) == 0) growing = 1'b0;
        else if (!growing && shadow_count == 0) growing = 1'b1;
        else if ($urandom_range(399) == 0) growing = !growing;
        req_backlog.push_back(random_request(growing));
      end
      wait_until_drained();
    end

    // any late or extra response shows up in the monitor meanwhile
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d request transfers and %0d responses, list depth up to %0d",
             req_transfers, rsp_transfers, peak_count);
    $display("statuses seen: ok %0d, full %0d, empty %0d, bad %0d; entries returned %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BAD], hits_seen);
    if (fail_count == 0 && awaited_rsp.size() == 0) begin
      $display("PASS bounded_ordered_list_engine_core");
    end else begin
      $display("FAIL bounded_ordered_list_engine_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bole_pkg.sv
hdl/bole_if.sv
hdl/bole_cell.sv
hdl/bole_chain.sv
hdl/bounded_ordered_list_engine_core.sv
hdl/bole_checker.sv
bench/bounded_ordered_list_engine_core_test.sv
